// ===== sv/imu_ca_pkg.sv =====
`timescale 1ns / 1ps
// imu_ca_pkg: constants, state type and lookup functions for the attitude block
// no dependencies

package imu_ca_pkg;

    localparam int ANGLE_FRAC_BITS   = 8;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int TBL_LEN           = 24;
    localparam int DIV_W             = 35;  // dividend magnitude bits
    localparam int NUM_W             = 36;  // signed numerator bits
    localparam int CW                = 28;  // cordic datapath bits

    // config register indexes
    localparam logic [2:0] REG_AX_OFF = 3'd0;
    localparam logic [2:0] REG_AY_OFF = 3'd1;
    localparam logic [2:0] REG_AZ_OFF = 3'd2;
    localparam logic [2:0] REG_GX_OFF = 3'd3;
    localparam logic [2:0] REG_GY_OFF = 3'd4;
    localparam logic [2:0] REG_GZ_OFF = 3'd5;
    localparam logic [2:0] REG_WEIGHT = 3'd6;

    // division job indexes
    localparam logic [3:0] DV_TEMP = 4'd0;
    localparam logic [3:0] DV_AX   = 4'd1;
    localparam logic [3:0] DV_AY   = 4'd2;
    localparam logic [3:0] DV_AZ   = 4'd3;
    localparam logic [3:0] DV_GX   = 4'd4;
    localparam logic [3:0] DV_GY   = 4'd5;
    localparam logic [3:0] DV_GZ   = 4'd6;
    localparam logic [3:0] DV_IX   = 4'd7;
    localparam logic [3:0] DV_IY   = 4'd8;
    localparam logic [3:0] DV_IZ   = 4'd9;

    localparam logic [2:0] ACT_CLEAR = 3'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_NUM, S_DIV, S_DSTORE, S_SQ0, S_SQ1, S_SQRT, S_CINIT,
        S_CORD, S_CDONE, S_BL0, S_BL1, S_BL2, S_YAW, S_DONE
    } t_state;

    // atan(2^-i) in degrees * 2^16
    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // divisor of each division job
    function automatic logic [16:0] div_const(input logic [3:0] k);
        logic [16:0] v;
        case (k) inside
            DV_TEMP:         v = 17'd3400;
            [DV_AX:DV_AZ]:   v = 17'd1600;
            [DV_GX:DV_GZ]:   v = 17'd131;
            default:         v = 17'd131000;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/imu_complementary_attitude.sv =====
`timescale 1ns / 1ps
// imu_complementary_attitude: offset removal, scaling, cordic attitude and
// complementary filter for one imu sample per transfer; uses imu_ca_pkg

// One sample is taken at a time: o_s_tready is high only while the block is
// idle. Each sample runs ten jobs in the bit-serial divider (temperature,
// three accel, three gyro scalings and three angle increments; each job has a
// setup state, a state that forms 35 quotient bits and a store state).
// S_SQ0 and S_SQ1 square the accel y and z terms, and a square root of their
// sum follows (one result bit per cycle, 24 result bits). Two cordic runs,
// roll then pitch, each have an init state, CORDIC_STEPS rotation steps and
// a done state. Blend states S_BL0 to S_BL2 run for roll and then pitch,
// S_YAW wraps yaw, and S_DONE loads the result register, after which the
// next sample can be taken. A clear action (tuser high) skips the
// computation and goes straight to S_DONE. The result register holds a
// finished result while the next sample is being worked on. A second finished
// result waits until the first is taken, and the input stalls meanwhile.

module imu_complementary_attitude
    import imu_ca_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, temp_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw, elapsed_ms
    input  logic [127:0] i_s_tdata,
    // action
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // roll_out, pitch_out, yaw_out, temp_out, accel_x_out, accel_y_out,
    // accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out, zero fill
    output logic [167:0] o_m_tdata
);

    localparam logic [5:0] STEP_LAST = 6'(CORDIC_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(DIV_W - 1);
    localparam logic [5:0] SQRT_LAST = 6'd23;

    t_state r_state, n_state;

    logic signed [15:0] r_ax_off, r_ay_off, r_az_off, r_gx_off, r_gy_off, r_gz_off;
    logic [8:0]         r_weight;

    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz, r_tr;
    logic [9:0]         r_dt;
    logic [8:0]         r_w;

    logic [3:0]         r_k;
    logic [5:0]         r_cnt;
    logic               r_phase;

    logic [16:0]        r_dv;
    logic               r_neg;
    logic [DIV_W-1:0]   r_dq;
    logic [16:0]        r_rem;

    logic signed [16:0] r_temp;
    logic signed [15:0] r_axo, r_ayo, r_azo, r_gxo, r_gyo, r_gzo;
    logic signed [17:0] r_ix, r_iy, r_iz;

    logic [47:0]        r_sv, r_sr, r_sbit;
    logic signed [40:0] r_acc;

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic                 r_czero;
    logic signed [17:0]   r_acc_roll, r_acc_pitch;

    logic signed [17:0] r_roll, r_pitch;
    logic signed [16:0] r_yaw;

    logic               r_out_valid;
    logic [167:0]       r_out_data;

    logic               w_in_xfer, w_clear, w_load_out;

    // shared multiplier
    logic signed [19:0] w_ma, w_mb;
    logic signed [39:0] w_mp;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = i_s_tuser ? S_DONE : S_NUM;
            end
            S_NUM:    n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST) n_state = S_DSTORE;
            end
            S_DSTORE: n_state = (r_k == DV_IZ) ? S_SQ0 : S_NUM;
            S_SQ0:    n_state = S_SQ1;
            S_SQ1:    n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == SQRT_LAST) n_state = S_CINIT;
            end
            S_CINIT:  n_state = S_CORD;
            S_CORD: begin
                if (r_cnt == STEP_LAST) n_state = S_CDONE;
            end
            S_CDONE:  n_state = r_phase ? S_BL0 : S_CINIT;
            S_BL0:    n_state = S_BL1;
            S_BL1:    n_state = S_BL2;
            S_BL2:    n_state = r_phase ? S_YAW : S_BL0;
            S_YAW:    n_state = S_DONE;
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        w_load_out = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_NUM: begin
                case (r_k)
                    DV_TEMP: begin w_ma = 20'(r_tr); w_mb = 20'sd2560; end
                    DV_AX:   begin w_ma = 20'(r_ax); w_mb = 20'sd981;  end
                    DV_AY:   begin w_ma = 20'(r_ay); w_mb = 20'sd981;  end
                    DV_AZ:   begin w_ma = 20'(r_az); w_mb = 20'sd981;  end
                    DV_GX:   begin w_ma = 20'(r_gx); w_mb = 20'sd128;  end
                    DV_GY:   begin w_ma = 20'(r_gy); w_mb = 20'sd128;  end
                    DV_GZ:   begin w_ma = 20'(r_gz); w_mb = 20'sd128;  end
                    DV_IX:   begin w_ma = 20'(r_gx); w_mb = $signed({10'd0, r_dt}); end
                    DV_IY:   begin w_ma = 20'(r_gy); w_mb = $signed({10'd0, r_dt}); end
                    default: begin w_ma = 20'(r_gz); w_mb = $signed({10'd0, r_dt}); end
                endcase
            end
            S_SQ0: begin w_ma = 20'(r_ay); w_mb = 20'(r_ay); end
            S_SQ1: begin w_ma = 20'(r_az); w_mb = 20'(r_az); end
            S_BL0: begin
                w_ma = r_phase ? 20'(r_pitch) + 20'(r_iy) : 20'(r_roll) + 20'(r_ix);
                w_mb = $signed({11'd0, r_w});
            end
            S_BL1: begin
                w_ma = r_phase ? 20'(r_acc_pitch) : 20'(r_acc_roll);
                w_mb = $signed(20'd256 - {11'd0, r_w});
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_mp      = w_ma * w_mb;
    assign w_in_xfer = i_s_tvalid && o_s_tready;
    assign w_clear   = ({2'b0, i_s_tuser} == ACT_CLEAR);

    // ---------------- numerator and divider step ----------------
    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]        w_nabs;
    logic [DIV_W-1:0]        w_dvd;
    logic [17:0]             w_trial;
    logic                    w_ge;
    logic signed [NUM_W-1:0] w_quo;
    logic [16:0]             w_dk;

    always_comb begin
        w_dk = div_const(r_k);
        if (r_k == DV_TEMP) begin
            w_num = NUM_W'(w_mp) + 36'sd31795712;
        end else if (r_k >= DV_IX) begin
            w_num = NUM_W'(w_mp) <<< ANGLE_FRAC_BITS;
        end else begin
            w_num = NUM_W'(w_mp);
        end
        w_nabs  = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
        w_dvd   = DIV_W'(w_nabs) + DIV_W'(w_dk >> 1);
        w_trial = {r_rem, r_dq[DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dv});
        w_quo   = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    end

    // ---------------- square root step ----------------
    logic [47:0] w_st;
    logic [31:0] w_sumsq;
    always_comb begin
        w_st    = r_sr + r_sbit;
        w_sumsq = 32'(r_acc + 41'(w_mp));
    end

    // ---------------- cordic ----------------
    logic signed [CW-1:0] w_cin_x, w_cin_y, w_xs, w_ys;
    logic signed [CW-1:0] w_zround;
    logic signed [17:0]   w_angle;
    always_comb begin
        if (r_phase) begin
            w_cin_y = -(CW'(r_ax) <<< 8);
            w_cin_x = $signed({4'd0, r_sr[23:0]});
        end else begin
            w_cin_y = CW'(r_ay) <<< 8;
            w_cin_x = CW'(r_az) <<< 8;
        end
        w_xs     = r_cx >>> r_cnt[4:0];
        w_ys     = r_cy >>> r_cnt[4:0];
        // round deg*2^16 to deg*2^8, ties up
        w_zround = (r_cz + CW'(128)) >>> (16 - ANGLE_FRAC_BITS);
        w_angle  = r_czero ? 18'sd0 : 18'(w_zround);
    end

    // ---------------- blend and yaw ----------------
    logic signed [40:0] w_bl;
    logic signed [17:0] w_sat;
    logic signed [19:0] w_yt, w_yw;
    always_comb begin
        w_bl = (r_acc + 41'sd128) >>> 8;
        if (w_bl > 41'sd131071)       w_sat = 18'sd131071;
        else if (w_bl < -41'sd131072) w_sat = -18'sd131072;
        else                          w_sat = 18'(w_bl);
        w_yt = 20'(r_yaw) + 20'(r_iz) + 20'sd46080;
        if (w_yt < 0)                 w_yw = w_yt + 20'sd92160;
        else if (w_yt >= 20'sd92160)  w_yw = w_yt - 20'sd92160;
        else                          w_yw = w_yt;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ax_off    <= '0;
            r_ay_off    <= '0;
            r_az_off    <= '0;
            r_gx_off    <= '0;
            r_gy_off    <= '0;
            r_gz_off    <= '0;
            r_weight    <= 9'd246;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out)                     r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_AX_OFF: r_ax_off <= i_cfg_wdata;
                    REG_AY_OFF: r_ay_off <= i_cfg_wdata;
                    REG_AZ_OFF: r_az_off <= i_cfg_wdata;
                    REG_GX_OFF: r_gx_off <= i_cfg_wdata;
                    REG_GY_OFF: r_gy_off <= i_cfg_wdata;
                    REG_GZ_OFF: r_gz_off <= i_cfg_wdata;
                    REG_WEIGHT: r_weight <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    r_k     <= DV_TEMP;
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                    if (w_in_xfer && w_clear) begin
                        r_roll  <= '0;
                        r_pitch <= '0;
                        r_yaw   <= '0;
                    end
                end
                S_NUM:    r_cnt <= '0;
                S_DIV:    r_cnt <= r_cnt + 6'd1;
                S_DSTORE: r_k   <= r_k + 4'd1;
                S_SQ1:    r_cnt <= '0;
                S_SQRT:   r_cnt <= (r_cnt == SQRT_LAST) ? 6'd0 : r_cnt + 6'd1;
                S_CINIT:  r_cnt <= '0;
                S_CORD:   r_cnt <= r_cnt + 6'd1;
                S_CDONE:  r_phase <= ~r_phase;
                S_BL2: begin
                    if (r_phase) r_pitch <= w_sat;
                    else         r_roll  <= w_sat;
                    r_phase <= ~r_phase;
                end
                S_YAW:    r_yaw <= 17'(w_yw - 20'sd46080);
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_ax <= i_s_tdata[15:0]   - r_ax_off;
                    r_ay <= i_s_tdata[31:16]  - r_ay_off;
                    r_az <= i_s_tdata[47:32]  - r_az_off;
                    r_tr <= i_s_tdata[63:48];
                    r_gx <= i_s_tdata[79:64]  - r_gx_off;
                    r_gy <= i_s_tdata[95:80]  - r_gy_off;
                    r_gz <= i_s_tdata[111:96] - r_gz_off;
                    if (i_s_tdata[127:112] == 16'd0 || i_s_tdata[127:112] > 16'd1000) begin
                        r_dt <= 10'd10;
                    end else begin
                        r_dt <= i_s_tdata[121:112];
                    end
                    r_w <= (r_weight > 9'd256) ? 9'd256 : r_weight;
                    if (w_clear) begin
                        r_temp <= '0;
                        r_axo  <= '0;
                        r_ayo  <= '0;
                        r_azo  <= '0;
                        r_gxo  <= '0;
                        r_gyo  <= '0;
                        r_gzo  <= '0;
                    end
                end
            end
            S_NUM: begin
                r_dv  <= w_dk;
                r_neg <= w_num[NUM_W-1];
                r_dq  <= w_dvd;
                r_rem <= '0;
            end
            S_DIV: begin
                // one quotient bit per cycle, dividend shifts out as quotient shifts in
                r_rem <= w_ge ? 17'(w_trial - {1'b0, r_dv}) : 17'(w_trial);
                r_dq  <= {r_dq[DIV_W-2:0], w_ge};
            end
            S_DSTORE: begin
                case (r_k)
                    DV_TEMP: r_temp <= 17'(w_quo);
                    DV_AX:   r_axo  <= 16'(w_quo);
                    DV_AY:   r_ayo  <= 16'(w_quo);
                    DV_AZ:   r_azo  <= 16'(w_quo);
                    DV_GX:   r_gxo  <= 16'(w_quo);
                    DV_GY:   r_gyo  <= 16'(w_quo);
                    DV_GZ:   r_gzo  <= 16'(w_quo);
                    DV_IX:   r_ix   <= 18'(w_quo);
                    DV_IY:   r_iy   <= 18'(w_quo);
                    default: r_iz   <= 18'(w_quo);
                endcase
            end
            S_SQ0: r_acc <= 41'(w_mp);
            S_SQ1: begin
                r_sv   <= {w_sumsq, 16'd0};
                r_sr   <= '0;
                r_sbit <= 48'd1 << 46;
            end
            S_SQRT: begin
                if (r_sv >= w_st) begin
                    r_sv <= r_sv - w_st;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            S_CINIT: begin
                r_czero <= (w_cin_x == 0) && (w_cin_y == 0);
                if (w_cin_x < 0) begin
                    if (w_cin_y >= 0) begin
                        r_cx <= w_cin_y;
                        r_cy <= -w_cin_x;
                        r_cz <= CW'(90 * 65536);
                    end else begin
                        r_cx <= -w_cin_y;
                        r_cy <= w_cin_x;
                        r_cz <= -CW'(90 * 65536);
                    end
                end else begin
                    r_cx <= w_cin_x;
                    r_cy <= w_cin_y;
                    r_cz <= '0;
                end
            end
            S_CORD: begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + $signed({6'd0, atan_tab(r_cnt[4:0])});
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - $signed({6'd0, atan_tab(r_cnt[4:0])});
                end
            end
            S_CDONE: begin
                if (r_phase) r_acc_pitch <= w_angle;
                else         r_acc_roll  <= w_angle;
            end
            S_BL0: r_acc <= 41'(w_mp);
            S_BL1: r_acc <= r_acc + 41'(w_mp);
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {2'b00, r_gzo, r_gyo, r_gxo, r_azo, r_ayo, r_axo,
                           r_temp, r_yaw, r_pitch, r_roll};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTH
    // yaw always stays in its wrapped range
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_yaw >= -17'sd46080) && (r_yaw <= 17'sd46079))
        else $error("yaw left wrapped range");

    // a clear transfer zeroes the angles and goes straight to delivery
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=>
        (r_state == S_DONE && r_roll == 0 && r_pitch == 0 && r_yaw == 0))
        else $error("clear did not zero the angles");

    // the divider only runs for the ten scaling jobs
    a_div_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_k <= DV_IZ))
        else $error("divider job index out of range");
`endif

endmodule
